// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AST_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AST_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/rbms_pkg.sv
// ----------------------------------------------------------------------------
// rbms_pkg
// Types and constants of the random burst motion scheduler.
// ----------------------------------------------------------------------------
package rbms_pkg;

  localparam logic [31:0] LCG_MUL        = 32'd1103515245;
  localparam logic [31:0] LCG_INC        = 32'd12345;
  localparam logic [31:0] LCG_SEED       = 32'd12345;
  localparam logic [15:0] INTERVAL_RESET = 16'd5000;
  localparam logic [11:0] LEN_LO         = 12'd1000;
  localparam logic [31:0] GAP_LO         = 32'd50;
  localparam logic [4:0]  DELTA_LO       = 5'd15;   // subtracted
  localparam logic [4:0]  RETRY_LO       = 5'd1;
  localparam int          RECIP_SHIFT    = 20;

  localparam logic [0:0]  REG_INTERVAL   = 1'b0;

  typedef enum logic [1:0] {
    SPAN_LEN,
    SPAN_DELTA,
    SPAN_GAP,
    SPAN_RETRY
  } span_sel_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_QUO,
    PH_REM
  } rng_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CYCLE,
    ST_LEN,
    ST_BURST,
    ST_DX,
    ST_DY,
    ST_RX,
    ST_RY,
    ST_GAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic      start;
    logic      add;
    span_sel_t span;
  } rng_ctl_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [10:0] value;
  } rng_sts_t;

  function automatic logic [10:0] span_of(span_sel_t s);
    logic [10:0] r;
    case (s)
      SPAN_LEN:   r = 11'd2001;
      SPAN_DELTA: r = 11'd31;
      SPAN_GAP:   r = 11'd151;
      SPAN_RETRY: r = 11'd3;
      default:    r = 11'd3;
    endcase
    return r;
  endfunction

  // floor(2^20 / span)
  function automatic logic [18:0] recip_of(span_sel_t s);
    logic [18:0] r;
    case (s)
      SPAN_LEN:   r = 19'd524;
      SPAN_DELTA: r = 19'd33825;
      SPAN_GAP:   r = 19'd6944;
      SPAN_RETRY: r = 19'd349525;
      default:    r = 19'd349525;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/rbms_rng.sv
// ----------------------------------------------------------------------------
// rbms_rng
// Shared LCG with ranged draw: state step, reciprocal multiply, remainder fix.
// ----------------------------------------------------------------------------
module rbms_rng (
  input  logic                clk,
  input  logic                rst,
  input  rbms_pkg::rng_ctl_t  ctl,
  input  logic [31:0]         add_val,
  output rbms_pkg::rng_sts_t  sts
);

  rbms_pkg::rng_phase_t phase, phase_next;
  rbms_pkg::span_sel_t  sel;
  logic [31:0] lcg_state;
  logic [14:0] raw_q;
  logic [33:0] prod;
  logic [13:0] quo;
  logic [15:0] rem_a;
  logic [15:0] rem_b;
  logic [10:0] span;
  logic        done;
  logic [10:0] value;

  assign span  = rbms_pkg::span_of(sel);
  assign quo   = prod[33:rbms_pkg::RECIP_SHIFT];
  assign rem_a = {1'b0, raw_q} - ({2'b0, quo} * {5'b0, span});
  assign rem_b = (rem_a >= {5'b0, span}) ? rem_a - {5'b0, span} : rem_a;

  always_comb begin
    phase_next = phase;
    case (phase)
      rbms_pkg::PH_IDLE: if (ctl.start) phase_next = rbms_pkg::PH_QUO;
      rbms_pkg::PH_QUO:  phase_next = rbms_pkg::PH_REM;
      rbms_pkg::PH_REM:  phase_next = rbms_pkg::PH_IDLE;
      default:           phase_next = rbms_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= rbms_pkg::PH_IDLE;
      lcg_state <= rbms_pkg::LCG_SEED;
      done      <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == rbms_pkg::PH_REM);
      if (phase == rbms_pkg::PH_IDLE && ctl.start) begin
        lcg_state <= 32'(lcg_state * rbms_pkg::LCG_MUL) + rbms_pkg::LCG_INC;
      end else if (phase == rbms_pkg::PH_IDLE && ctl.add) begin
        lcg_state <= lcg_state + add_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase == rbms_pkg::PH_IDLE && ctl.start) sel <= ctl.span;
    if (phase == rbms_pkg::PH_QUO) begin
      raw_q <= lcg_state[30:16];
      prod  <= {19'b0, lcg_state[30:16]} * {15'b0, rbms_pkg::recip_of(sel)};
    end
    if (phase == rbms_pkg::PH_REM) value <= rem_b[10:0];
  end

  assign sts.busy  = (phase != rbms_pkg::PH_IDLE);
  assign sts.done  = done;
  assign sts.value = value;

endmodule

// File: rtl/random_burst_motion_scheduler.sv
// ----------------------------------------------------------------------------
// random_burst_motion_scheduler
// Poll-driven motion burst scheduler with LCG-drawn lengths, gaps and deltas.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_stall  | now_ms, report_ready
//  out     | out_valid / out_stall| send_move, delta_x, delta_y
//  cfg     | APB psel/penable     | burst interval register at 0x0
//
//  A poll is accepted in ST_IDLE, decided in ST_CYCLE and ST_BURST, makes
//  up to six random draws in the shared LCG multiplier, and is handed off
//  in ST_DONE.
//  One poll is worked at a time; in_stall is high while a poll is in work.
//  A finished beat waits in the output register; the next poll is taken
//  meanwhile and only stalls at its end if that beat is still held.
//  rst is synchronous; the LCG seed and cycle interval return to defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module random_burst_motion_scheduler (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       now_ms,
  input  logic              report_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              send_move,
  output logic signed [4:0] delta_x,
  output logic signed [4:0] delta_y
);

  rbms_pkg::state_t   state, state_next;
  rbms_pkg::rng_ctl_t ctl;
  rbms_pkg::rng_sts_t sts;

  logic [15:0] interval;
  logic [31:0] now_r;
  logic        ready_r;
  logic [31:0] cycle_start;
  logic [31:0] burst_start;
  logic [11:0] burst_length;
  logic [31:0] next_move;
  logic        burst_active;
  logic        cycle_begun;
  logic [4:0]  dx_w;
  logic [4:0]  dy_w;
  logic        send_w;

  logic elapsed;
  logic burst_go;
  logic both_zero;
  logic out_free;
  logic draw_wait;

  rbms_rng u_rng (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .add_val (now_r),
    .sts     (sts)
  );

  assign pready    = 1'b1;
  assign prdata    = {16'b0, interval};
  assign elapsed   = (now_r - cycle_start) >= {16'b0, interval};
  assign burst_go  = cycle_begun && burst_active && (now_r >= next_move);
  assign both_zero = (dx_w == 5'd0) && (sts.value == 11'(rbms_pkg::DELTA_LO));
  assign out_free  = !out_valid || !out_stall;
  assign draw_wait = state inside {rbms_pkg::ST_LEN, rbms_pkg::ST_DX, rbms_pkg::ST_DY,
                                   rbms_pkg::ST_RX, rbms_pkg::ST_RY, rbms_pkg::ST_GAP};

  always_comb begin
    state_next = state;
    case (state)
      rbms_pkg::ST_IDLE:  if (in_valid) state_next = rbms_pkg::ST_CYCLE;
      rbms_pkg::ST_CYCLE: state_next = elapsed ? rbms_pkg::ST_LEN : rbms_pkg::ST_BURST;
      rbms_pkg::ST_LEN:   if (sts.done) state_next = rbms_pkg::ST_BURST;
      rbms_pkg::ST_BURST: begin
        if (!burst_go) state_next = rbms_pkg::ST_DONE;
        else if (ready_r) state_next = rbms_pkg::ST_DX;
        else state_next = rbms_pkg::ST_GAP;
      end
      rbms_pkg::ST_DX:    if (sts.done) state_next = rbms_pkg::ST_DY;
      rbms_pkg::ST_DY: begin
        if (sts.done) state_next = both_zero ? rbms_pkg::ST_RX : rbms_pkg::ST_GAP;
      end
      rbms_pkg::ST_RX:    if (sts.done) state_next = rbms_pkg::ST_RY;
      rbms_pkg::ST_RY:    if (sts.done) state_next = rbms_pkg::ST_GAP;
      rbms_pkg::ST_GAP:   if (sts.done) state_next = rbms_pkg::ST_DONE;
      rbms_pkg::ST_DONE:  if (out_free) state_next = rbms_pkg::ST_IDLE;
      default:            state_next = rbms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != rbms_pkg::ST_IDLE);
    ctl.start = 1'b0;
    ctl.add   = 1'b0;
    ctl.span  = rbms_pkg::SPAN_GAP;
    case (state)
      rbms_pkg::ST_CYCLE: begin
        ctl.start = elapsed;
        ctl.span  = rbms_pkg::SPAN_LEN;
      end
      rbms_pkg::ST_LEN:   ctl.add = sts.done;
      rbms_pkg::ST_BURST: begin
        ctl.start = burst_go;
        ctl.span  = ready_r ? rbms_pkg::SPAN_DELTA : rbms_pkg::SPAN_GAP;
      end
      rbms_pkg::ST_DX: begin
        ctl.start = sts.done;
        ctl.span  = rbms_pkg::SPAN_DELTA;
      end
      rbms_pkg::ST_DY: begin
        ctl.start = sts.done;
        ctl.span  = both_zero ? rbms_pkg::SPAN_RETRY : rbms_pkg::SPAN_GAP;
      end
      rbms_pkg::ST_RX: begin
        ctl.start = sts.done;
        ctl.span  = rbms_pkg::SPAN_RETRY;
      end
      rbms_pkg::ST_RY: begin
        ctl.start = sts.done;
        ctl.span  = rbms_pkg::SPAN_GAP;
      end
      default: begin
        ctl.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rbms_pkg::ST_IDLE;
      interval     <= rbms_pkg::INTERVAL_RESET;
      cycle_start  <= 32'd0;
      burst_start  <= 32'd0;
      burst_length <= 12'd0;
      next_move    <= 32'd0;
      burst_active <= 1'b0;
      cycle_begun  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && paddr[2] == rbms_pkg::REG_INTERVAL) begin
        interval <= pwdata[15:0];
      end
      if (state == rbms_pkg::ST_CYCLE && elapsed) begin
        cycle_start  <= now_r;
        burst_start  <= now_r;
        cycle_begun  <= 1'b1;
        burst_active <= 1'b1;
        next_move    <= now_r;
      end
      if (state == rbms_pkg::ST_LEN && sts.done) begin
        burst_length <= 12'(sts.value) + rbms_pkg::LEN_LO;
      end
      if (state == rbms_pkg::ST_BURST && cycle_begun && burst_active &&
          (now_r - burst_start) >= {20'b0, burst_length}) begin
        burst_active <= 1'b0;
      end
      if (state == rbms_pkg::ST_GAP && sts.done) begin
        next_move <= now_r + 32'(sts.value) + rbms_pkg::GAP_LO;
      end
      if (state == rbms_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rbms_pkg::ST_IDLE && in_valid) begin
      now_r   <= now_ms;
      ready_r <= report_ready;
      send_w  <= 1'b0;
      dx_w    <= 5'd0;
      dy_w    <= 5'd0;
    end
    if (sts.done) begin
      case (state)
        rbms_pkg::ST_DX: dx_w <= sts.value[4:0] - rbms_pkg::DELTA_LO;
        rbms_pkg::ST_DY: begin
          dy_w   <= sts.value[4:0] - rbms_pkg::DELTA_LO;
          send_w <= 1'b1;
        end
        rbms_pkg::ST_RX: dx_w <= sts.value[4:0] + rbms_pkg::RETRY_LO;
        rbms_pkg::ST_RY: dy_w <= sts.value[4:0] + rbms_pkg::RETRY_LO;
        default: begin
          send_w <= send_w;
        end
      endcase
    end
    if (state == rbms_pkg::ST_DONE && out_free) begin
      send_move <= send_w;
      delta_x   <= dx_w;
      delta_y   <= dy_w;
    end
  end

  `AST_NXT(a_accept_to_cycle, clk, rst, in_valid && !in_stall, state == rbms_pkg::ST_CYCLE)
  `AST_IMP(a_start_when_free, clk, rst, ctl.start, !sts.busy)
  `AST_IMP(a_done_in_draw, clk, rst, sts.done, draw_wait)
  `AST_IMP(a_idle_zero, clk, rst, out_valid && !send_move, delta_x == 5'sd0 && delta_y == 5'sd0)

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the random burst motion scheduler.
// Polls carry a millisecond time that mostly walks forward, with jumps, wraps
// and scattered random values. Each accepted poll is run through a local
// model of the burst scheduler and its LCG draws. The move it predicts is
// queued and compared with the next output beat. The cycle interval is set
// over APB between phases, covering 1, 65535, 0 and random values. The
// sender idles in bursts, the receiver stalls on shifting patterns, and it
// holds off at times long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] INTERVAL_ADDR = {rbms_pkg::REG_INTERVAL, 2'b00};
  localparam logic [2:0] UNUSED_ADDR   = 3'd4;
  localparam int unsigned LEN_SPAN     = 2001;
  localparam int unsigned DELTA_SPAN   = 31;
  localparam int unsigned GAP_SPAN     = 151;
  localparam int unsigned RETRY_SPAN   = 3;
  localparam int          HOLD_PERIOD  = 4000;
  localparam int          HOLD_CYCLES  = 250;

  typedef struct {
    logic [31:0] now;
    logic        ready;
  } poll_t;

  typedef struct {
    logic       send;
    logic [4:0] dx;
    logic [4:0] dy;
  } move_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [31:0]       now_ms;
  logic              report_ready;
  logic              out_valid;
  logic              out_stall;
  logic              send_move;
  logic signed [4:0] delta_x;
  logic signed [4:0] delta_y;

  random_burst_motion_scheduler dut (.*);

  // scheduler state mirror
  bit [31:0] rng;
  bit [31:0] cyc_start;
  bit [31:0] burst_t0;
  bit [31:0] move_at;
  bit [11:0] burst_len;
  bit        in_burst;
  bit        started;
  bit [15:0] interval;

  poll_t pending_polls[$];
  move_t expected_moves[$];
  bit [31:0] clock_ms;
  int errors;
  logic in_accept;
  int run_left;
  int idle_left;
  int rx_cyc;
  int hold_left;
  int mode_left;
  stall_mode_t stall_mode;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned draw(int unsigned span);
    rng = rng * rbms_pkg::LCG_MUL + rbms_pkg::LCG_INC;
    return ((rng >> 16) & 32'h7FFF) % span;
  endfunction

  function automatic move_t predict_poll(bit [31:0] now, bit ready);
    move_t m;
    int dx;
    int dy;
    dx = 0;
    dy = 0;
    m.send = 1'b0;
    if (now - cyc_start >= {16'd0, interval}) begin
      cyc_start = now;
      burst_t0  = now;
      started   = 1'b1;
      in_burst  = 1'b1;
      burst_len = 12'(1000 + draw(LEN_SPAN));
      move_at   = now;
      rng       = rng + now;
    end
    if (started && in_burst) begin
      if (now - burst_t0 >= {20'd0, burst_len}) in_burst = 1'b0;
      if (now >= move_at) begin
        if (ready) begin
          dx = int'(draw(DELTA_SPAN)) - 15;
          dy = int'(draw(DELTA_SPAN)) - 15;
          if (dx == 0 && dy == 0) begin
            dx = 1 + int'(draw(RETRY_SPAN));
            dy = 1 + int'(draw(RETRY_SPAN));
          end
          m.send = 1'b1;
        end
        move_at = now + 50 + draw(GAP_SPAN);
      end
    end
    m.dx = dx[4:0];
    m.dy = dy[4:0];
    return m;
  endfunction

  // prediction and checking
  always @(posedge clk) begin
    move_t exp_m;
    in_accept <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (expected_moves.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat send=%0b dx=%0d dy=%0d", $time, send_move,
                 delta_x, delta_y);
      end else begin
        exp_m = expected_moves.pop_front();
        if (send_move !== exp_m.send) begin
          errors++;
          $display("%0t: send_move expected %0b got %0b", $time, exp_m.send, send_move);
        end
        if (delta_x !== exp_m.dx) begin
          errors++;
          $display("%0t: delta_x expected %0d got %0d", $time, $signed(exp_m.dx), delta_x);
        end
        if (delta_y !== exp_m.dy) begin
          errors++;
          $display("%0t: delta_y expected %0d got %0d", $time, $signed(exp_m.dy), delta_y);
        end
      end
    end
    if (!rst && in_valid && !in_stall)
      expected_moves.push_back(predict_poll(now_ms, report_ready));
  end

  // poll sender
  always @(negedge clk) begin
    poll_t p;
    if (!rst && !(in_valid && !in_accept)) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        in_valid  <= 1'b0;
      end else if (pending_polls.size() > 0) begin
        p = pending_polls.pop_front();
        now_ms       <= p.now;
        report_ready <= p.ready;
        in_valid     <= 1'b1;
        if (run_left <= 1) begin
          run_left  <= $urandom_range(1, 24);
          idle_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          run_left <= run_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with a periodic long hold-off set by HOLD_PERIOD and HOLD_CYCLES
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (rx_cyc % HOLD_PERIOD == HOLD_PERIOD - 1) begin
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= stall_mode_t'($urandom_range(0, 3));
          mode_left  <= $urandom_range(64, 512);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= rx_cyc[0];
        endcase
      end
    end
  end

  task automatic push_poll(bit [31:0] now, bit ready);
    poll_t p;
    p.now   = now;
    p.ready = ready;
    pending_polls.push_back(p);
  endtask

  task automatic queue_polls(int count, int unsigned max_step);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        push_poll($urandom, $urandom_range(0, 1));
      end else begin
        if (pick < 5) clock_ms += $urandom;
        else clock_ms += $urandom_range(0, max_step);
        push_poll(clock_ms, $urandom_range(0, 7) != 0);
      end
    end
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == INTERVAL_ADDR) interval = data[15:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (pending_polls.size() != 0 || in_valid || expected_moves.size() != 0)
      @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    int unsigned iv;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    now_ms       = '0;
    report_ready = 1'b0;
    out_stall    = 1'b0;
    run_left     = 0;
    idle_left    = 0;
    rx_cyc       = 0;
    hold_left    = 0;
    mode_left    = 0;
    stall_mode   = STALL_NONE;
    errors       = 0;
    rng          = rbms_pkg::LCG_SEED;
    cyc_start    = '0;
    burst_t0     = '0;
    move_at      = '0;
    burst_len    = '0;
    in_burst     = 1'b0;
    started      = 1'b0;
    interval     = rbms_pkg::INTERVAL_RESET;

    // directed: cycle start, not ready, burst end, time wrap, high bits
    push_poll(32'd0, 1'b1);
    push_poll(32'd4999, 1'b1);
    push_poll(32'd5000, 1'b1);
    push_poll(32'd5001, 1'b1);
    push_poll(32'd5300, 1'b0);
    push_poll(32'd5301, 1'b1);
    push_poll(32'd5600, 1'b1);
    push_poll(32'd5601, 1'b1);
    push_poll(32'd5900, 1'b1);
    push_poll(32'd6900, 1'b1);
    push_poll(32'd8100, 1'b1);
    push_poll(32'd8400, 1'b1);
    push_poll(32'd10000, 1'b0);
    push_poll(32'd10001, 1'b1);
    push_poll(32'hFFFF_FFF0, 1'b1);
    push_poll(32'hFFFF_FFFF, 1'b1);
    push_poll(32'd0, 1'b1);
    push_poll(32'd100, 1'b1);
    push_poll(32'd250, 1'b1);
    push_poll(32'h8000_0000, 1'b0);
    push_poll(32'h7FFF_FFFF, 1'b1);
    clock_ms = 32'd400;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    drain();
    apb_write(UNUSED_ADDR, 32'd7);
    apb_write(INTERVAL_ADDR, 32'd5000);
    queue_polls(310, 60);
    drain();
    apb_write(INTERVAL_ADDR, 32'd1);
    queue_polls(310, 5);
    drain();
    apb_write(INTERVAL_ADDR, 32'd65535);
    queue_polls(310, 2000);
    drain();
    apb_write(INTERVAL_ADDR, 32'd0);
    queue_polls(310, 50);
    drain();
    iv = $urandom_range(100, 3000);
    apb_write(INTERVAL_ADDR, {16'($urandom), 16'(iv)});
    queue_polls(310, 60);
    drain();
    iv = $urandom_range(1, 65535);
    apb_write(INTERVAL_ADDR, 32'(iv));
    queue_polls(310, iv / 40 + 1);
    drain();

    if (expected_moves.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, expected_moves.size());
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
